// ----- sv/idac_pkg.sv -----
// Shared types and constants for the integer to decimal ASCII converter.
package idac_pkg;

  localparam int MAG_W  = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int STEPS  = MAG_W / BITS_PER_STEP;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [BCD_W-1:0] bcd_t;

endpackage

// ----- sv/int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII text, one character per item.
//
// Input channel value_valid/value_ready carries one signed 32-bit value.
// Output channel char_valid/char_ready carries one ASCII character per item,
// most significant first, with last_char set on the final character.
// A negative value starts with '-'; zero gives a single '0'.
// The magnitude goes through a double-dabble unit that handles two bits a
// cycle; characters then leave at one per cycle while char_ready is high.
// A number gives 1..11 characters; value_ready is low while it is
// converted and emitted.
// The output register is loaded only when empty or being taken, so a
// stall on char_ready simply holds the sequencer; nothing is dropped.
// value_ready returns once the last character sits in the output register.
// Synchronous reset empties the output register and returns to idle.
module int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        value_valid,
  output logic        value_ready,
  input  logic [31:0] value,
  output logic        char_valid,
  input  logic        char_ready,
  output logic [7:0]  char_code,
  output logic        last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]     state;
  logic [3:0]     cnt;
  logic [3:0]     pos;
  logic           sign_pending;
  idac_pkg::bcd_t bcd;
  idac_pkg::mag_t mag;

  idac_pkg::bcd_t bcd_mid, bcd_step;
  idac_pkg::mag_t mag_mid, mag_step;
  logic [3:0]     lead;
  logic [3:0]     digit;
  logic           load;

  idac_bcd_step u_step0 (
    .bcd_in (bcd),
    .mag_in (mag),
    .bcd_out(bcd_mid),
    .mag_out(mag_mid)
  );

  idac_bcd_step u_step1 (
    .bcd_in (bcd_mid),
    .mag_in (mag_mid),
    .bcd_out(bcd_step),
    .mag_out(mag_step)
  );

  // highest nonzero digit of the finished conversion
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < idac_pkg::DIGITS; i++) begin
      if (bcd_step[4*i +: 4] != 4'd0) begin
        lead = 4'(i);
      end
    end
  end

  assign digit       = bcd[pos*4 +: 4];
  assign value_ready = (state == ST_IDLE);
  assign load        = (state == ST_EMIT) && (!char_valid || char_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready && !load) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (value_valid) begin
            sign_pending <= value[31];
            mag          <= value[31] ? (32'd0 - value) : value;
            bcd          <= '0;
            cnt          <= 4'd0;
            state        <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= bcd_step;
          mag <= mag_step;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(idac_pkg::STEPS - 1)) begin
            pos   <= lead;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            char_valid <= 1'b1;
            if (sign_pending) begin
              char_code    <= idac_pkg::ASCII_MINUS;
              last_char    <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              char_code <= idac_pkg::ASCII_ZERO + {4'd0, digit};
              last_char <= (pos == 4'd0);
              if (pos == 4'd0) begin
                state <= ST_IDLE;
              end else begin
                pos <= pos - 4'd1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/idac_bcd_step.sv -----
// One shift-and-add-3 step of the binary to BCD converter.
module idac_bcd_step (
  input  idac_pkg::bcd_t bcd_in,
  input  idac_pkg::mag_t mag_in,
  output idac_pkg::bcd_t bcd_out,
  output idac_pkg::mag_t mag_out
);

  idac_pkg::bcd_t adj;

  always_comb begin
    adj = bcd_in;
    for (int i = 0; i < idac_pkg::DIGITS; i++) begin
      if (bcd_in[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
      end
    end
  end

  assign bcd_out = {adj[idac_pkg::BCD_W-2:0], mag_in[idac_pkg::MAG_W-1]};
  assign mag_out = {mag_in[idac_pkg::MAG_W-2:0], 1'b0};

endmodule
